// File: rtl/rolt_pkg.sv
`default_nettype none

package rolt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int ID_W              = 32;
   localparam int HANDLE_W          = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// File: rtl/rolt_ram.sv
`default_nettype none

module rolt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rolt_ctrl.sv
`default_nettype none

module rolt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire rolt_pkg::dp_sts_type sts,
   output rolt_pkg::ctl_cmd_type     cmd
);

   import rolt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last slot read is compared in this cycle.
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/rolt_datapath.sv
`default_nettype none

module rolt_datapath #(
   parameter int TABLE_ENTRIES = rolt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rolt_pkg::ctl_cmd_type             cmd,
   output rolt_pkg::dp_sts_type                   sts,
   input  wire logic                              req_operation,
   input  wire logic [rolt_pkg::ID_W-1:0]         req_range_low,
   input  wire logic [rolt_pkg::ID_W-1:0]         req_range_high,
   input  wire logic [rolt_pkg::HANDLE_W-1:0]     req_owner_handle,
   input  wire logic [rolt_pkg::ID_W-1:0]         req_query_id,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic                                   rsp_found,
   output logic      [rolt_pkg::HANDLE_W-1:0]     rsp_result_handle,
   output logic                                   rsp_table_full
);

   import rolt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   // Item held for the duration of the scan.
   logic                op_ff;
   logic [ID_W-1:0]     lo_ff;
   logic [ID_W-1:0]     hi_ff;
   logic [HANDLE_W-1:0] h_ff;
   logic [ID_W-1:0]     qid_ff;

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   logic                match_ff, match_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                hit_ff, hit_in;
   logic [ID_W-1:0]     best_low_ff, best_low_in;
   logic [HANDLE_W-1:0] best_handle_ff, best_handle_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                rsp_full_ff, rsp_full_in;

   logic [2*ID_W-1:0]   bounds_rd;
   logic [ID_W-1:0]     rd_low;
   logic [ID_W-1:0]     rd_high;
   logic [HANDLE_W-1:0] rd_handle;

   logic                slot_v;
   logic                is_insert;
   logic                bounds_we;
   logic                handle_we;
   logic [IDX_W-1:0]    handle_waddr;

   assign rd_low    = bounds_rd[2*ID_W-1:ID_W];
   assign rd_high   = bounds_rd[ID_W-1:0];
   assign is_insert = (op_ff == OP_INSERT);
   assign slot_v    = valid_ff[cmp_idx_ff];

   assign bounds_we    = cmd.commit && is_insert && !match_ff && free_ff;
   assign handle_we    = cmd.commit && is_insert && (match_ff || free_ff);
   assign handle_waddr = match_ff ? match_idx_ff : free_idx_ff;

   rolt_ram #(
      .WIDTH (2*ID_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_bounds_ram (
      .clock   (clock),
      .wr_en   (bounds_we),
      .wr_addr (free_idx_ff),
      .wr_data ({lo_ff, hi_ff}),
      .rd_en   (cmd.issue),
      .rd_addr (cnt_ff),
      .rd_data (bounds_rd)
   );

   rolt_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (handle_we),
      .wr_addr (handle_waddr),
      .wr_data (h_ff),
      .rd_en   (cmd.issue),
      .rd_addr (cnt_ff),
      .rd_data (rd_handle)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         lo_ff  <= req_range_low;
         hi_ff  <= req_range_high;
         h_ff   <= req_owner_handle;
         qid_ff <= req_query_id;
      end
      cnt_ff         <= cnt_in;
      cmp_idx_ff     <= cmp_idx_in;
      match_idx_ff   <= match_idx_in;
      free_idx_ff    <= free_idx_in;
      best_low_ff    <= best_low_in;
      best_handle_ff <= best_handle_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_full_ff    <= rsp_full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff   <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_vld_ff   <= cmp_vld_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
         hit_ff       <= hit_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan: one slot read is issued per cycle and compared in the cycle after.
   always_comb begin
      cnt_in         = cnt_ff;
      cmp_vld_in     = cmd.issue;
      cmp_idx_in     = cnt_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      hit_in         = hit_ff;
      best_low_in    = best_low_ff;
      best_handle_in = best_handle_ff;

      if (cmd.load) begin
         cnt_in   = '0;
         match_in = 1'b0;
         free_in  = 1'b0;
         hit_in   = 1'b0;
      end else if (cmd.issue) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmp_vld_ff) begin
         if (is_insert) begin
            if (slot_v && !match_ff && (rd_low == lo_ff)) begin
               match_in     = 1'b1;
               match_idx_in = cmp_idx_ff;
            end
            if (!slot_v && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
         end else begin
            if (slot_v && (rd_low <= qid_ff) && (rd_high >= qid_ff)
                && (!hit_ff || (rd_low < best_low_ff))) begin
               hit_in         = 1'b1;
               best_low_in    = rd_low;
               best_handle_in = rd_handle;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (bounds_we) begin
         valid_in[free_idx_ff] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_full_in   = rsp_full_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (is_insert) begin
            rsp_found_in  = match_ff;
            rsp_handle_in = '0;
            rsp_full_in   = !match_ff && !free_ff;
         end else begin
            rsp_found_in  = hit_ff;
            rsp_handle_in = hit_ff ? best_handle_ff : '0;
            rsp_full_in   = 1'b0;
         end
      end
   end

   assign sts.last     = (cnt_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_table_full    = rsp_full_ff;

endmodule

`default_nettype wire

// File: rtl/range_owner_lookup_table.sv
// Each insert or lookup scans all TABLE_ENTRIES slots, one slot per cycle through the read
// ports of the bounds and handle RAMs, then does the last compare in the drain state and
// the commit in the commit state, which waits while the result beat is stalled. One item
// is in flight at a time, so a new beat is taken only after the last one has committed.
// Reset is synchronous and active high; it clears all slot valid bits and the
// controller, so the table reads as empty right after reset.
`default_nettype none

module range_owner_lookup_table #(
   parameter int TABLE_ENTRIES = rolt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_operation,
   input  wire logic [rolt_pkg::ID_W-1:0]     req_range_low,
   input  wire logic [rolt_pkg::ID_W-1:0]     req_range_high,
   input  wire logic [rolt_pkg::HANDLE_W-1:0] req_owner_handle,
   input  wire logic [rolt_pkg::ID_W-1:0]     req_query_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_found,
   output logic      [rolt_pkg::HANDLE_W-1:0] rsp_result_handle,
   output logic                               rsp_table_full
);

   import rolt_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   rolt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rolt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .req_owner_handle  (req_owner_handle),
      .req_query_id      (req_query_id),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_result_handle (rsp_result_handle),
      .rsp_table_full    (rsp_table_full)
   );

endmodule

`default_nettype wire

// File: rtl/rolt_checker.sv
`default_nettype none

module rolt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_found,
   input wire logic [15:0] rsp_result_handle,
   input wire logic        rsp_table_full
);

   // A dropped insert never also reports a low-bound match.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_table_full && rsp_found))
      else $error("table_full and found both set");

   // A nonzero handle only comes back from a lookup hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_handle != 16'd0)) |-> rsp_found)
      else $error("nonzero handle without found");

   // The table works on one item at a time, so an accepted beat stalls the next.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted back to back");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_result_handle)
          && $stable(rsp_table_full)))
      else $error("stalled result beat changed");

endmodule

bind range_owner_lookup_table rolt_checker u_rolt_checker (.*);

`default_nettype wire

// File: tb/tb_range_owner_lookup_table.sv
`timescale 1ns / 100ps

module tb_range_owner_lookup_table;
   import rolt_pkg::*;

   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
   localparam int RANDOM_ITEMS  = 1000;

   typedef struct packed {
      logic                found;
      logic [HANDLE_W-1:0] handle;
      logic                full;
   } owner_rsp_type;

   // Tracks the table contents and the responses still owed by the block.
   class owner_table_scoreboard;
      bit                  slot_used [TABLE_ENTRIES];
      logic [ID_W-1:0]     slot_lo [TABLE_ENTRIES];
      logic [ID_W-1:0]     slot_hi [TABLE_ENTRIES];
      logic [HANDLE_W-1:0] slot_owner [TABLE_ENTRIES];
      owner_rsp_type       pending_rsp[$];
      int                  errors;

      function new();
         errors = 0;
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            slot_used[k] = 1'b0;
         end
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      // Returns a random occupied slot, or -1 while the table is empty.
      function int pick_used_slot();
         int used[$];
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (slot_used[k]) used.push_back(k);
         end
         if (used.size() == 0) return -1;
         return used[$urandom_range(0, used.size() - 1)];
      endfunction

      function void note_request(logic op, logic [ID_W-1:0] lo, logic [ID_W-1:0] hi,
                                 logic [HANDLE_W-1:0] owner, logic [ID_W-1:0] id);
         owner_rsp_type   rsp;
         int              free_slot;
         bit              hit;
         logic [ID_W-1:0] best_lo;
         rsp       = '0;
         free_slot = -1;
         hit       = 1'b0;
         best_lo   = '0;
         if (op == OP_INSERT) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
               if (slot_used[k] && slot_lo[k] == lo && !rsp.found) begin
                  // A matching low bound only takes the new owner; the old high stays.
                  slot_owner[k] = owner;
                  rsp.found     = 1'b1;
               end
               if (!slot_used[k] && free_slot < 0) free_slot = k;
            end
            if (!rsp.found) begin
               if (free_slot >= 0) begin
                  slot_used[free_slot]  = 1'b1;
                  slot_lo[free_slot]    = lo;
                  slot_hi[free_slot]    = hi;
                  slot_owner[free_slot] = owner;
               end else begin
                  rsp.full = 1'b1;
               end
            end
         end else begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
               if (slot_used[k] && slot_lo[k] <= id && slot_hi[k] >= id) begin
                  if (!hit || slot_lo[k] < best_lo) begin
                     hit        = 1'b1;
                     best_lo    = slot_lo[k];
                     rsp.handle = slot_owner[k];
                  end
               end
            end
            rsp.found = hit;
         end
         pending_rsp.push_back(rsp);
      endfunction

      function void check_response(logic found, logic [HANDLE_W-1:0] handle, logic full);
         owner_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response beat with none expected: found=%0d handle=%h full=%0d",
                     $time, found, handle, full);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0d, actual %0d", $time, want.found, found);
            errors++;
         end
         if (handle !== want.handle) begin
            $display("%0t: result_handle mismatch: expected %h, actual %h",
                     $time, want.handle, handle);
            errors++;
         end
         if (full !== want.full) begin
            $display("%0t: table_full mismatch: expected %0d, actual %0d", $time, want.full, full);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_operation = OP_INSERT;
   logic [ID_W-1:0]     req_range_low = '0;
   logic [ID_W-1:0]     req_range_high = '0;
   logic [HANDLE_W-1:0] req_owner_handle = '0;
   logic [ID_W-1:0]     req_query_id = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic [HANDLE_W-1:0] rsp_result_handle;
   logic                rsp_table_full;

   int send_idle_pct = 10;
   int recv_stall_pct = 81;

   owner_table_scoreboard sb = new();

   range_owner_lookup_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .req_owner_handle (req_owner_handle),
      .req_query_id     (req_query_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_result_handle(rsp_result_handle),
      .rsp_table_full   (rsp_table_full)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         sb.check_response(rsp_found, rsp_result_handle, rsp_table_full);
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_item(logic op, logic [ID_W-1:0] lo, logic [ID_W-1:0] hi,
                            logic [HANDLE_W-1:0] owner, logic [ID_W-1:0] id);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_operation    = op;
      req_range_low    = lo;
      req_range_high   = hi;
      req_owner_handle = owner;
      req_query_id     = id;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, lo, hi, owner, id);
      @(negedge clock);
   endtask

   task automatic insert_range(logic [ID_W-1:0] lo, logic [ID_W-1:0] hi,
                               logic [HANDLE_W-1:0] owner);
      send_item(OP_INSERT, lo, hi, owner, $urandom);
   endtask

   task automatic lookup_id(logic [ID_W-1:0] id);
      send_item(OP_LOOKUP, $urandom, $urandom, HANDLE_W'($urandom_range(0, 65535)), id);
   endtask

   initial begin
      int                  k;
      int                  sel;
      logic [ID_W-1:0]     lo;
      logic [ID_W-1:0]     hi;
      longint unsigned     span;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed part: empty table, bound extremes, inverted range, equal low, overlap.
      lookup_id(32'h0000_0000);
      lookup_id(32'hFFFF_FFFF);
      insert_range(32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      insert_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001);
      insert_range(32'd200, 32'd100, 16'h1234);
      lookup_id(32'd150);
      lookup_id(32'd200);
      lookup_id(32'h0000_0000);
      lookup_id(32'hFFFF_FFFF);
      insert_range(32'h0000_0000, 32'd1000, 16'h0000);
      lookup_id(32'd1);
      lookup_id(32'h0000_0000);
      insert_range(32'd1000, 32'd2000, 16'hAAAA);
      insert_range(32'd500, 32'd3000, 16'h5555);
      lookup_id(32'd1500);
      lookup_id(32'd2500);
      lookup_id(32'd3000);
      lookup_id(32'd3001);
      lookup_id(32'd499);
      insert_range(32'd200, 32'd9999, 16'hBEEF);
      lookup_id(32'd200);
      lookup_id(32'hFFFF_FFFE);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (n * 3 / RANDOM_ITEMS)
            0: begin
               send_idle_pct  = 10;
               recv_stall_pct = 81;
            end
            1: begin
               send_idle_pct  = 81;
               recv_stall_pct = 10;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         k   = sb.pick_used_slot();
         sel = $urandom_range(0, 9);
         if ($urandom_range(0, 1)) begin
            if (k >= 0 && sel < 6) begin
               lo = sb.slot_lo[k];
               hi = sb.slot_hi[k];
               case (sel)
                  0: lookup_id(lo);
                  1: lookup_id(hi);
                  2: lookup_id(lo - 1);
                  3: lookup_id(hi + 1);
                  default: begin
                     if (lo <= hi) begin
                        span = longint'(hi) - longint'(lo) + 1;
                        lookup_id(lo + ID_W'(longint'($urandom) % span));
                     end else begin
                        lookup_id(lo);
                     end
                  end
               endcase
            end else if (sel < 8) begin
               lookup_id($urandom_range(0, 5000));
            end else begin
               lookup_id($urandom);
            end
         end else begin
            if (k >= 0 && $urandom_range(0, 1)) begin
               insert_range(sb.slot_lo[k], $urandom, HANDLE_W'($urandom_range(0, 65535)));
            end else if (sel == 0) begin
               insert_range($urandom, $urandom, HANDLE_W'($urandom_range(0, 65535)));
            end else if (sel == 1) begin
               lo = $urandom_range(100, 5000);
               insert_range(lo, lo - $urandom_range(1, 100),
                            HANDLE_W'($urandom_range(0, 65535)));
            end else begin
               lo = $urandom_range(0, 4000);
               insert_range(lo, lo + $urandom_range(0, 1500),
                            HANDLE_W'($urandom_range(0, 65535)));
            end
         end
      end
      req_valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout with %0d responses outstanding", $time, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
rtl/rolt_pkg.sv
rtl/rolt_ram.sv
rtl/rolt_ctrl.sv
rtl/rolt_datapath.sv
rtl/range_owner_lookup_table.sv
rtl/rolt_checker.sv
tb/tb_range_owner_lookup_table.sv
